// ===== rtl/edfps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared sizes, input kinds and sequencer states of the EDF scheduler core.
// ----------------------------------------------------------------------------
package edfps_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CFG_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int VAL_W    = 16;
  localparam int TIME_W   = 24;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 80;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

// ===== rtl/edf_preemptive_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF preemptive scheduler core
// Task table with earliest-deadline-first selection, one time unit per tick.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of transaction, chosen by in_tuser. A
// load writes arrival, burst and deadline into one table slot. A tick scans
// the slots in use, one slot per cycle through a single deadline comparator.
// It then updates the chosen task in ST_UPD, settles the turnaround sum in
// ST_FIN and places the result in ST_OUT. A tick keeps in_tready low until
// its result is placed, and it produces exactly one result transaction;
// loads produce none. Results sit in an output register, so a new
// transaction is accepted while an earlier result still waits; a tick whose
// result cannot be placed holds in its last step until the receiver takes
// the old one.
// The user must write the entry count register through cfg_wr_en and
// cfg_wr_data only while the core is idle; the core itself does not enforce
// this. Reset clears the clock, the running task and the entry count; table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module edf_preemptive_scheduler_core import edfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index, arrival, burst, deadline, zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tick_time, running_index, task_finished, wait_ticks, turnaround_ticks,
  // all_done, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // idle
  output logic                  out_tuser
);

  logic [VAL_W-1:0] arr_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] bst_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] dl_mem  [MAX_ENTRIES];
  logic [VAL_W-1:0] rem_mem [MAX_ENTRIES];

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  entry_count_r;
  logic [TIME_W-1:0] clock_r;
  logic [IDX_W-1:0]  cur_task_r;
  logic              cur_valid_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_r;
  logic [VAL_W-1:0]  best_dl_r;
  logic              cur_rdy_r;
  logic [VAL_W-1:0]  cur_dl_r;
  logic [CNT_W-1:0]  nz_cnt_r;

  logic [TIME_W-1:0] res_time_r;
  logic              res_idle_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic              res_fin_r;
  logic [TIME_W-1:0] res_wait_r;
  logic [VAL_W-1:0]  res_burst_r;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_user_r;

  logic [CNT_W-1:0]  n_use;
  logic [IDX_W-1:0]  rd_idx;
  logic [VAL_W-1:0]  rd_arr, rd_bst, rd_dl, rd_rem;
  logic              rd_ready;
  logic [IDX_W-1:0]  pick;
  logic [TIME_W:0]   finish;
  logic [VAL_W:0]    spent;
  logic [TIME_W:0]   wait_diff;
  logic [TIME_W-1:0] wait_c;
  logic [TIME_W:0]   turn_sum;
  logic [TIME_W-1:0] turn_c;
  logic              all_done_c;
  logic              out_free;
  logic              in_acc;
  logic [SLOT_W-1:0] in_slot;

  assign in_acc   = in_tvalid && in_tready;
  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    if (32'(entry_count_r) > MAX_ENTRIES) begin
      n_use = CNT_W'(MAX_ENTRIES);
    end else begin
      n_use = CNT_W'(entry_count_r);
    end
  end

  always_comb begin
    if (cur_valid_r && cur_rdy_r && (best_dl_r >= cur_dl_r)) begin
      pick = cur_task_r;
    end else begin
      pick = best_r;
    end
  end

  assign rd_idx   = (state_r == ST_SCAN) ? scan_cnt_r[IDX_W-1:0] : pick;
  assign rd_arr   = arr_mem[rd_idx];
  assign rd_bst   = bst_mem[rd_idx];
  assign rd_dl    = dl_mem[rd_idx];
  assign rd_rem   = rem_mem[rd_idx];
  assign rd_ready = (TIME_W'(rd_arr) <= clock_r) && (rd_rem != '0);

  assign finish    = {1'b0, clock_r} + (TIME_W+1)'(1);
  assign spent     = {1'b0, rd_bst} + {1'b0, rd_arr};
  assign wait_diff = finish - (TIME_W+1)'(spent);
  always_comb begin
    if (finish <= (TIME_W+1)'(spent)) begin
      wait_c = '0;
    end else if (wait_diff[TIME_W]) begin
      wait_c = TIME_MAX;
    end else begin
      wait_c = wait_diff[TIME_W-1:0];
    end
  end

  assign turn_sum   = {1'b0, res_wait_r} + (TIME_W+1)'(res_burst_r);
  assign turn_c     = turn_sum[TIME_W] ? TIME_MAX : turn_sum[TIME_W-1:0];
  assign all_done_c = (nz_cnt_r == '0) || ((nz_cnt_r == CNT_W'(1)) && res_fin_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == KIND_TICK)) begin
          state_nxt = (n_use == '0) ? ST_UPD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == n_use - CNT_W'(1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      clock_r       <= '0;
      cur_task_r    <= '0;
      cur_valid_r   <= 1'b0;
      scan_cnt_r    <= '0;
      found_r       <= 1'b0;
      cur_rdy_r     <= 1'b0;
      nz_cnt_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          scan_cnt_r <= '0;
          found_r    <= 1'b0;
          cur_rdy_r  <= 1'b0;
          nz_cnt_r   <= '0;
        end
        ST_SCAN: begin
          scan_cnt_r <= scan_cnt_r + CNT_W'(1);
          if (rd_rem != '0) begin
            nz_cnt_r <= nz_cnt_r + CNT_W'(1);
          end
          if (rd_ready && (!found_r || (rd_dl < best_dl_r))) begin
            found_r <= 1'b1;
          end
          if (rd_idx == cur_task_r) begin
            cur_rdy_r <= rd_ready;
          end
        end
        ST_UPD: begin
          if (clock_r != TIME_MAX) begin
            clock_r <= clock_r + TIME_W'(1);
          end
          if (!found_r) begin
            cur_valid_r <= 1'b0;
          end else begin
            cur_task_r  <= pick;
            cur_valid_r <= (rd_rem != VAL_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == KIND_LOAD) && (32'(in_slot) < MAX_ENTRIES)) begin
      arr_mem[IDX_W'(in_slot)] <= in_tdata[SLOT_W +: VAL_W];
      bst_mem[IDX_W'(in_slot)] <= in_tdata[SLOT_W+VAL_W +: VAL_W];
      dl_mem[IDX_W'(in_slot)]  <= in_tdata[SLOT_W+2*VAL_W +: VAL_W];
      rem_mem[IDX_W'(in_slot)] <= in_tdata[SLOT_W+VAL_W +: VAL_W];
    end else if ((state_r == ST_UPD) && found_r) begin
      rem_mem[pick] <= rd_rem - VAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      if (rd_ready && (!found_r || (rd_dl < best_dl_r))) begin
        best_r    <= rd_idx;
        best_dl_r <= rd_dl;
      end
      if (rd_idx == cur_task_r) begin
        cur_dl_r <= rd_dl;
      end
    end
    if (state_r == ST_UPD) begin
      res_time_r  <= clock_r;
      res_idle_r  <= !found_r;
      res_idx_r   <= found_r ? pick : '0;
      res_fin_r   <= found_r && (rd_rem == VAL_W'(1));
      res_wait_r  <= (found_r && (rd_rem == VAL_W'(1))) ? wait_c : '0;
      res_burst_r <= (found_r && (rd_rem == VAL_W'(1))) ? rd_bst : '0;
    end
    if ((state_r == ST_OUT) && out_free) begin
      out_user_r <= res_idle_r;
      out_data_r <= OUT_DATA_W'({all_done_c, turn_c, res_wait_r, res_fin_r,
                                 SLOT_W'(res_idx_r), res_time_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_idle_no_task: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[TIME_W+SLOT_W-1:TIME_W] == '0)
                                  && !out_tdata[TIME_W+SLOT_W])
    else $error("idle result reports a task");

  a_turn_ge_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[TIME_W+SLOT_W]) |->
      (out_tdata[2*TIME_W+SLOT_W+1 +: TIME_W] >= out_tdata[TIME_W+SLOT_W+1 +: TIME_W]))
    else $error("turnaround below waiting time");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == KIND_TICK)) |=> !in_tready)
    else $error("tick accepted without taking the sequencer");

endmodule

// ===== bench/edf_schedule_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler result checker
// Watches the configuration port and both streams of the EDF scheduler core,
// keeps its own copy of the task table, predicts the result of every tick
// transaction and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module edf_schedule_checker import edfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    mismatch_count,
  output int                    pending_results,
  output int                    finished_tasks,
  output int                    idle_ticks
);

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              idle;
    logic [SLOT_W-1:0] running_index;
    logic              task_finished;
    logic [TIME_W-1:0] wait_ticks;
    logic [TIME_W-1:0] turnaround_ticks;
    logic              all_done;
  } sched_result_t;

  logic [VAL_W-1:0]  arrival_tbl   [MAX_ENTRIES];
  logic [VAL_W-1:0]  burst_tbl     [MAX_ENTRIES];
  logic [VAL_W-1:0]  deadline_tbl  [MAX_ENTRIES];
  logic [VAL_W-1:0]  remaining_tbl [MAX_ENTRIES];
  logic [SLOT_W-1:0] running_slot;
  logic              running_valid;
  logic [TIME_W-1:0] sched_clock;
  logic [CFG_W-1:0]  slots_configured;

  sched_result_t expected_results[$];

  function automatic int unsigned slots_in_use();
    return (slots_configured < MAX_ENTRIES) ? slots_configured : MAX_ENTRIES;
  endfunction

  function automatic logic slot_ready(int unsigned slot);
    return slot < slots_in_use() && TIME_W'(arrival_tbl[slot]) <= sched_clock &&
           remaining_tbl[slot] != '0;
  endfunction

  function automatic sched_result_t schedule_tick();
    sched_result_t   res;
    int unsigned     best;
    int unsigned     pick;
    logic            found;
    logic [TIME_W:0] finish;
    logic [TIME_W:0] spent;
    logic [TIME_W:0] waited;
    logic [TIME_W:0] turnaround;
    res   = '0;
    best  = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < slots_in_use(); i++) begin
      if (slot_ready(i) && (!found || deadline_tbl[i] < deadline_tbl[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    res.tick_time = sched_clock;
    if (!found) begin
      running_valid = 1'b0;
      res.idle      = 1'b1;
    end else begin
      pick = best;
      if (running_valid && slot_ready(running_slot) &&
          deadline_tbl[best] >= deadline_tbl[running_slot]) begin
        pick = running_slot;
      end
      remaining_tbl[pick] = remaining_tbl[pick] - 1'b1;
      running_slot        = SLOT_W'(pick);
      running_valid       = 1'b1;
      res.running_index   = SLOT_W'(pick);
      if (remaining_tbl[pick] == '0) begin
        finish     = {1'b0, sched_clock} + 1'b1;
        spent      = (TIME_W+1)'(burst_tbl[pick]) + (TIME_W+1)'(arrival_tbl[pick]);
        waited     = (finish > spent) ? finish - spent : '0;
        if (waited > TIME_MAX) begin
          waited = TIME_MAX;
        end
        turnaround = (TIME_W+1)'(burst_tbl[pick]) + waited;
        if (turnaround > TIME_MAX) begin
          turnaround = TIME_MAX;
        end
        running_valid        = 1'b0;
        res.task_finished    = 1'b1;
        res.wait_ticks       = waited[TIME_W-1:0];
        res.turnaround_ticks = turnaround[TIME_W-1:0];
      end
    end
    res.all_done = 1'b1;
    for (int unsigned i = 0; i < slots_in_use(); i++) begin
      if (remaining_tbl[i] != '0) begin
        res.all_done = 1'b0;
      end
    end
    if (sched_clock != TIME_MAX) begin
      sched_clock = sched_clock + 1'b1;
    end
    return res;
  endfunction

  task automatic compare_result(input sched_result_t want, input sched_result_t got);
    string diff;
    diff = "";
    if (got.tick_time !== want.tick_time) diff = {diff, " tick_time"};
    if (got.idle !== want.idle) diff = {diff, " idle"};
    if (got.running_index !== want.running_index) diff = {diff, " running_index"};
    if (got.task_finished !== want.task_finished) diff = {diff, " task_finished"};
    if (got.wait_ticks !== want.wait_ticks) diff = {diff, " wait_ticks"};
    if (got.turnaround_ticks !== want.turnaround_ticks) diff = {diff, " turnaround_ticks"};
    if (got.all_done !== want.all_done) diff = {diff, " all_done"};
    if (diff != "") begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Mismatch in%s", diff);
        $display("  expected time=%0d idle=%0b slot=%0d fin=%0b wait=%0d turn=%0d done=%0b",
                 want.tick_time, want.idle, want.running_index, want.task_finished,
                 want.wait_ticks, want.turnaround_ticks, want.all_done);
        $display("  actual   time=%0d idle=%0b slot=%0d fin=%0b wait=%0d turn=%0d done=%0b",
                 got.tick_time, got.idle, got.running_index, got.task_finished,
                 got.wait_ticks, got.turnaround_ticks, got.all_done);
      end
    end
  endtask

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    logic [SLOT_W-1:0] slot;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        arrival_tbl[i]   = '0;
        burst_tbl[i]     = '0;
        deadline_tbl[i]  = '0;
        remaining_tbl[i] = '0;
      end
      running_slot     = '0;
      running_valid    = 1'b0;
      sched_clock      = '0;
      slots_configured = '0;
      mismatch_count   = 0;
      finished_tasks   = 0;
      idle_ticks       = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en === 1'b1) begin
        slots_configured = cfg_wr_data;
      end
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got.tick_time        = out_tdata[0 +: TIME_W];
        got.idle             = out_tuser;
        got.running_index    = out_tdata[TIME_W +: SLOT_W];
        got.task_finished    = out_tdata[TIME_W+SLOT_W];
        got.wait_ticks       = out_tdata[TIME_W+SLOT_W+1 +: TIME_W];
        got.turnaround_ticks = out_tdata[2*TIME_W+SLOT_W+1 +: TIME_W];
        got.all_done         = out_tdata[3*TIME_W+SLOT_W+1];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected result transaction at tick_time=%0d", got.tick_time);
          end
        end else begin
          want = expected_results.pop_front();
          compare_result(want, got);
          if (want.task_finished) finished_tasks++;
          if (want.idle) idle_ticks++;
        end
      end
      if (in_tvalid === 1'b1 && in_tready === 1'b1) begin
        if (in_tuser == KIND_TICK) begin
          expected_results.push_back(schedule_tick());
        end else begin
          slot                = in_tdata[0 +: SLOT_W];
          arrival_tbl[slot]   = in_tdata[SLOT_W +: VAL_W];
          burst_tbl[slot]     = in_tdata[SLOT_W+VAL_W +: VAL_W];
          deadline_tbl[slot]  = in_tdata[SLOT_W+2*VAL_W +: VAL_W];
          remaining_tbl[slot] = burst_tbl[slot];
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== bench/tb_edf_preemptive_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler core testbench
// Drives load and tick transactions into the scheduler core across many
// entry_count settings, with random gaps and stalls on both streams and one
// long receiver hold-off. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_edf_preemptive_scheduler_core import edfps_pkg::*; ();

  localparam int ITEM_TARGET  = 1650;
  localparam int LOAD_SETTLE  = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int mismatch_count;
  int pending_results;
  int finished_tasks;
  int idle_ticks;

  int items_sent;
  int loads_sent;
  int ticks_sent;
  int setting_count;
  int cycle_count;
  bit no_gap;
  bit hold_request;
  bit hold_done;

  edf_preemptive_scheduler_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  edf_schedule_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .finished_tasks  (finished_tasks),
    .idle_ticks      (idle_ticks)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                 pending_results);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_task(logic [SLOT_W-1:0] slot,
                                                     logic [VAL_W-1:0] arrival,
                                                     logic [VAL_W-1:0] burst,
                                                     logic [VAL_W-1:0] deadline);
    return IN_DATA_W'({deadline, burst, arrival, slot});
  endfunction

  task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
    if (kind == KIND_TICK) ticks_sent++;
    else loads_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_slot(input int slot, input int arrival, input int burst,
                           input int deadline);
    send_item(KIND_LOAD, pack_task(SLOT_W'(slot), VAL_W'(arrival), VAL_W'(burst),
                                   VAL_W'(deadline)));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, pack_task(SLOT_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                                   VAL_W'($urandom)));
  endtask

  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic set_entry_count(input int count);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(count);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    setting_count++;
  endtask

  initial begin
    int roll;
    int stall;
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        roll  = $urandom_range(0, 99);
        stall = pick_gap();
        if (roll < 5) begin
          repeat ($urandom_range(100, 200)) @(posedge clk);
        end else if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_tready <= 1'b1;
        end else begin
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int slot_count;
    int base;
    int work;
    int burst;
    int tick_total;
    int roll;
    items_sent    = 0;
    loads_sent    = 0;
    ticks_sent    = 0;
    setting_count = 0;
    no_gap        = 1'b0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= KIND_LOAD;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, table extremes, ties, preemption, zero burst,
    // and a running task reloaded with a later arrival.
    set_entry_count(0);
    send_tick();
    load_slot(0, 0, 3, 20);
    load_slot(1, 0, 2, 20);
    load_slot(2, 1, 1, 5);
    load_slot(3, 0, 0, 0);
    load_slot(4, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 5; i < MAX_ENTRIES; i++) begin
      load_slot(i, 16'hFFFF, 1, i);
    end
    set_entry_count(MAX_ENTRIES);
    repeat (3) send_tick();
    load_slot(0, 16'h00FF, 2, 1);
    repeat (3) send_tick();

    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) slot_count = MAX_ENTRIES;
      else if (roll < 15) slot_count = 0;
      else if (roll < 20) slot_count = 1;
      else slot_count = $urandom_range(1, MAX_ENTRIES);
      set_entry_count(slot_count);
      no_gap = ($urandom_range(0, 3) == 0);
      base = ticks_sent;
      work = 0;
      for (int i = 0; i < slot_count; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) burst = 0;
        else if (roll < 85) burst = $urandom_range(1, 6);
        else burst = $urandom_range(7, 40);
        work += burst;
        if ($urandom_range(0, 99) < 15) begin
          load_slot(i, base + $urandom_range(0, 12), burst, $urandom_range(0, 65535));
        end else begin
          load_slot(i, base + $urandom_range(0, 12), burst, base + $urandom_range(0, 40));
        end
      end
      if (slot_count < MAX_ENTRIES && $urandom_range(0, 99) < 15) begin
        load_slot($urandom_range(slot_count, MAX_ENTRIES - 1), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      tick_total = (slot_count == 0) ? $urandom_range(1, 4) : work + $urandom_range(0, 12);
      // The long receiver hold-off runs while ticks keep arriving.
      if (setting_count >= 5 && !hold_request) begin
        hold_request = 1'b1;
        tick_total += 20;
        wait (hold_done);
      end
      for (int t = 0; t < tick_total && items_sent < ITEM_TARGET; t++) begin
        roll = $urandom_range(0, 99);
        if (slot_count > 0 && roll < 3) begin
          load_slot($urandom_range(0, slot_count - 1), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (slot_count > 0 && roll < 7) begin
          load_slot($urandom_range(0, slot_count - 1), ticks_sent + $urandom_range(0, 5),
                    $urandom_range(1, 6), ticks_sent + $urandom_range(0, 30));
        end
        send_tick();
      end
    end

    wait_until_drained();
    $display("Run covered %0d load and %0d tick transactions over %0d entry_count settings.",
             loads_sent, ticks_sent, setting_count);
    $display("Scheduler completed %0d tasks and reported %0d idle ticks.", finished_tasks,
             idle_ticks);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("Failures: %0d mismatches, %0d results missing", mismatch_count,
               pending_results);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
